/* rtl/arow_pkg.sv */
// Shared constants, state codes and interface structs of the AROW classifier.
package arow_pkg;

    // Features per vector; the weight memory holds one more entry for the bias
    localparam int FEATURE_COUNT = 64;
    localparam int WDEPTH        = FEATURE_COUNT + 1;
    localparam int WADDR_W       = $clog2(WDEPTH);
    localparam int FADDR_W       = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int CNT_W         = WADDR_W;

    // Q16.16 one and the confidence ceiling
    localparam logic [31:0] ONE_Q    = 32'h0001_0000;
    localparam logic [47:0] CAP_CONF = 48'hFFFF_FFFF_FFFF;

    // Divider: one quotient bit per cycle, quotient below 2^33
    localparam int DIV_STEPS = 33;
    localparam int DSTEP_W   = $clog2(DIV_STEPS);

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_F_MW,
        ST_F_MM,
        ST_F_X2,
        ST_F_V1,
        ST_F_V2,
        ST_FIN,
        ST_FIN2,
        ST_U_V,
        ST_U_BW,
        ST_U_A1,
        ST_U_A2,
        ST_E_RD,
        ST_E_AC1,
        ST_E_AC2,
        ST_E_AC3,
        ST_E_D0,
        ST_E_D1,
        ST_E_D2,
        ST_E_X2,
        ST_E_T1,
        ST_E_T2,
        ST_E_DS,
        ST_E_DW,
        ST_RES
    } eng_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_STEPS-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [31:0] margin;
        logic        pred;
        logic        loss;
        logic        upd;
    } res_t;

endpackage

/* rtl/arow_div.sv */
// Restoring divider, one quotient bit per cycle, for beta and the new variances.
module arow_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  arow_pkg::div_req_t req,
    output arow_pkg::div_rsp_t rsp
);
    import arow_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DSTEP_W-1:0]   step_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          den_reg;
    logic [DIV_STEPS-1:0] nb_reg;
    logic [DIV_STEPS-1:0] q_reg;

    logic [64:0] trial;
    logic        ge;
    logic [64:0] rem_next;

    // One trial subtraction
    always_comb begin
        trial    = {rem_reg, nb_reg[DIV_STEPS-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DSTEP_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath; the top bits of the dividend seed the remainder
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= {{DIV_STEPS{1'b0}}, req.num[63:DIV_STEPS]};
            nb_reg  <= req.num[DIV_STEPS-1:0];
            den_reg <= req.den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next[63:0];
            nb_reg  <= {nb_reg[DIV_STEPS-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_STEPS-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

/* rtl/arow_engine.sv */
// Sequencer, weight and feature memories and shared multiplier of the classifier.
module arow_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_train,
    input  logic signed [31:0]  in_x,
    input  logic                in_pos,
    input  logic                in_last,
    input  logic [31:0]         rate,
    input  logic                out_free,
    output logic                res_valid,
    output arow_pkg::res_t      res
);
    import arow_pkg::*;

    localparam logic signed [49:0] SUM_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] SUM_MIN = -50'sd140737488355328;
    localparam logic signed [48:0] M_MAX   = 49'sd2147483647;
    localparam logic signed [48:0] M_MIN   = -49'sd2147483648;
    localparam logic signed [34:0] D_MAX   = 35'sd2147483647;
    localparam logic signed [34:0] D_MIN   = -35'sd2147483648;

    eng_state_t state_reg, state_next;

    // Memories: weights {mean, variance}, features of the current vector
    logic [63:0] wmem [WDEPTH];
    logic [31:0] fmem [FEATURE_COUNT];
    logic [63:0] wrd_reg;
    logic [31:0] frd_reg;

    logic               w_we, w_re, f_we, f_re;
    logic [WADDR_W-1:0] w_waddr, w_raddr;
    logic [63:0]        w_wdata;
    logic [FADDR_W-1:0] f_waddr, f_raddr;

    // Datapath registers
    logic [CNT_W-1:0]   cnt_reg;
    logic [WADDR_W-1:0] clr_reg;
    logic [WADDR_W-1:0] idx_reg;
    logic signed [47:0] msum_reg;
    logic [47:0]        csum_reg;
    logic signed [31:0] x_reg;
    logic               train_reg, pos_reg, last_reg;
    logic [63:0]        prod_reg, acc_reg;
    logic [46:0]        x2_reg;
    logic [47:0]        alpha_reg;
    logic [48:0]        ac_reg;
    logic [31:0]        a_reg;
    logic [32:0]        beta_reg;
    logic [31:0]        nmean_reg;
    logic [63:0]        d_reg;
    logic signed [31:0] m_reg;
    logic               loss_reg, upd_reg;

    logic [31:0] mul_a, mul_b;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    arow_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Memory ports, read data registered
    always_ff @(posedge aclk) begin
        if (w_we) wmem[w_waddr] <= w_wdata;
        if (w_re) wrd_reg <= wmem[w_raddr];
        if (f_we) fmem[f_waddr] <= in_x;
        if (f_re) frd_reg <= fmem[f_raddr];
    end

    // Shared 32x32 multiplier, registered product
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Arithmetic around the memory read and the product
    logic signed [31:0] rd_mean;
    logic [31:0]        rd_var, mag, wmag, r_eff;
    logic               neg, up, last_elem;
    logic [49:0]        pext;
    logic signed [49:0] msum_add;
    logic signed [47:0] msum_new;
    logic [95:0]        sum96;
    logic [79:0]        sh;
    logic [47:0]        cval;
    logic [48:0]        csum_add;
    logic [47:0]        csum_new;
    logic [46:0]        x2_new;
    logic [48:0]        ac_new;
    logic [33:0]        delta;
    logic signed [34:0] dsum;
    logic [31:0]        mean_new;
    logic [62:0]        tval;
    logic [63:0]        d_new;
    logic [48:0]        vsum;
    logic [47:0]        vcap;
    logic [48:0]        bden;
    logic signed [48:0] msum_b;
    logic signed [31:0] m_new;
    logic signed [33:0] ym;
    logic signed [33:0] aval;
    logic               upd_new;

    always_comb begin
        rd_mean  = $signed(wrd_reg[63:32]);
        rd_var   = wrd_reg[31:0];
        mag      = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
        wmag     = rd_mean[31] ? (~rd_mean + 32'd1) : rd_mean;
        r_eff    = (rate == 32'd0) ? 32'd1 : rate;
        neg      = rd_mean[31] ^ x_reg[31];
        up       = pos_reg ^ x_reg[31];
        last_elem = (idx_reg == WADDR_W'(FEATURE_COUNT));

        // margin accumulation, saturated to 48 bits
        pext     = {2'b00, prod_reg[63:16]};
        msum_add = $signed({{2{msum_reg[47]}}, msum_reg}) +
                   (neg ? -$signed(pext) : $signed(pext));
        if (msum_add > SUM_MAX)      msum_new = SUM_MAX[47:0];
        else if (msum_add < SUM_MIN) msum_new = SUM_MIN[47:0];
        else                         msum_new = msum_add[47:0];

        // low partial product plus high partial product shifted by 32
        sum96 = {32'b0, acc_reg} + {prod_reg, 32'b0};
        sh    = sum96[95:16];

        cval     = (|sum96[95:64]) ? CAP_CONF : sum96[63:16];
        csum_add = {1'b0, csum_reg} + {1'b0, cval};
        csum_new = csum_add[48] ? CAP_CONF : csum_add[47:0];

        x2_new = prod_reg[62:16];

        ac_new = (sh > 80'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : sh[48:0];
        delta  = (sh > 80'h2_0000_0000) ? 34'h2_0000_0000 : sh[33:0];

        // mean step, saturated to 32 bits
        dsum = $signed({{3{rd_mean[31]}}, rd_mean}) +
               (up ? $signed({1'b0, delta}) : -$signed({1'b0, delta}));
        if (dsum > D_MAX)      mean_new = D_MAX[31:0];
        else if (dsum < D_MIN) mean_new = D_MIN[31:0];
        else                   mean_new = dsum[31:0];

        // variance denominator r + var*x^2, capped
        tval  = (|sum96[95:64]) ? 63'h4000_0000_0000_0000 : {15'b0, sum96[63:16]};
        d_new = {1'b0, tval} + {32'b0, r_eff};

        // beta denominator: confidence plus bias variance, capped, plus r
        vsum = {1'b0, csum_reg} + {17'b0, rd_var};
        vcap = vsum[48] ? CAP_CONF : vsum[47:0];
        bden = {1'b0, vcap} + {17'b0, r_eff};

        // final margin with bias
        msum_b = $signed({msum_reg[47], msum_reg}) +
                 $signed({{17{rd_mean[31]}}, rd_mean});
        if (msum_b > M_MAX)      m_new = M_MAX[31:0];
        else if (msum_b < M_MIN) m_new = M_MIN[31:0];
        else                     m_new = msum_b[31:0];
        ym      = pos_reg ? $signed({{2{m_new[31]}}, m_new})
                          : -$signed({{2{m_new[31]}}, m_new});
        aval    = 34'sd65536 - ym;
        upd_new = train_reg && (ym < 34'sd65536);
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLR;
        else          state_reg <= state_next;
    end

    // Next state, memory controls and multiplier operands
    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        w_we       = 1'b0;
        w_waddr    = idx_reg;
        w_wdata    = {nmean_reg, div_rsp.quot[31:0]};
        w_re       = 1'b0;
        w_raddr    = idx_reg;
        f_we       = 1'b0;
        f_waddr    = cnt_reg[FADDR_W-1:0];
        f_re       = 1'b0;
        f_raddr    = idx_reg[FADDR_W-1:0];
        div_req    = '0;
        unique case (state_reg)
            ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = clr_reg;
                w_wdata = {32'b0, ONE_Q};
                if (clr_reg == WADDR_W'(FEATURE_COUNT)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (cnt_reg < CNT_W'(FEATURE_COUNT)) begin
                        w_re       = 1'b1;
                        w_raddr    = cnt_reg;
                        f_we       = 1'b1;
                        state_next = ST_F_MW;
                    end else if (in_last) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_F_MW: begin
                mul_a = wmag; mul_b = mag;
                state_next = ST_F_MM;
            end
            ST_F_MM: begin
                mul_a = mag; mul_b = mag;
                state_next = ST_F_X2;
            end
            ST_F_X2: begin
                mul_a = rd_var; mul_b = x2_new[31:0];
                state_next = ST_F_V1;
            end
            ST_F_V1: begin
                mul_a = rd_var; mul_b = {17'b0, x2_reg[46:32]};
                state_next = ST_F_V2;
            end
            ST_F_V2: begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                w_re       = 1'b1;
                w_raddr    = WADDR_W'(FEATURE_COUNT);
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                state_next = upd_new ? ST_U_V : ST_RES;
            end
            ST_U_V: begin
                div_req.start = 1'b1;
                div_req.num   = 64'h1_0000_0000;
                div_req.den   = {15'b0, bden};
                state_next    = ST_U_BW;
            end
            ST_U_BW: begin
                if (div_rsp.done) state_next = ST_U_A1;
            end
            ST_U_A1: begin
                mul_a = a_reg; mul_b = beta_reg[31:0];
                state_next = ST_U_A2;
            end
            ST_U_A2: begin
                state_next = ST_E_RD;
            end
            ST_E_RD: begin
                w_re       = 1'b1;
                f_re       = (idx_reg < WADDR_W'(FEATURE_COUNT));
                state_next = ST_E_AC1;
            end
            ST_E_AC1: begin
                mul_a = alpha_reg[31:0]; mul_b = rd_var;
                state_next = ST_E_AC2;
            end
            ST_E_AC2: begin
                mul_a = {16'b0, alpha_reg[47:32]}; mul_b = rd_var;
                state_next = ST_E_AC3;
            end
            ST_E_AC3: begin
                state_next = ST_E_D0;
            end
            ST_E_D0: begin
                mul_a = ac_reg[31:0]; mul_b = mag;
                state_next = ST_E_D1;
            end
            ST_E_D1: begin
                mul_a = {15'b0, ac_reg[48:32]}; mul_b = mag;
                state_next = ST_E_D2;
            end
            ST_E_D2: begin
                mul_a = mag; mul_b = mag;
                state_next = ST_E_X2;
            end
            ST_E_X2: begin
                mul_a = rd_var; mul_b = x2_new[31:0];
                state_next = ST_E_T1;
            end
            ST_E_T1: begin
                mul_a = rd_var; mul_b = {17'b0, x2_reg[46:32]};
                state_next = ST_E_T2;
            end
            ST_E_T2: begin
                mul_a = rd_var; mul_b = r_eff;
                state_next = ST_E_DS;
            end
            ST_E_DS: begin
                div_req.start = 1'b1;
                div_req.num   = prod_reg;
                div_req.den   = d_reg;
                state_next    = ST_E_DW;
            end
            ST_E_DW: begin
                if (div_rsp.done) begin
                    w_we       = 1'b1;
                    state_next = last_elem ? ST_RES : ST_E_RD;
                end
            end
            ST_RES: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers: feature count, sums, clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            msum_reg <= '0;
            csum_reg <= '0;
            clr_reg  <= '0;
        end else begin
            case (state_reg)
                ST_CLR:  clr_reg <= clr_reg + 1'b1;
                ST_F_MM: msum_reg <= msum_new;
                ST_F_V2: begin
                    csum_reg <= csum_new;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                ST_RES: begin
                    if (out_free) begin
                        cnt_reg  <= '0;
                        msum_reg <= '0;
                        csum_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    x_reg     <= in_x;
                    train_reg <= in_train;
                    pos_reg   <= in_pos;
                    last_reg  <= in_last;
                end
            end
            ST_F_X2: x2_reg <= x2_new;
            ST_F_V1: acc_reg <= prod_reg;
            ST_FIN2: begin
                m_reg    <= m_new;
                loss_reg <= train_reg && ym[33];
                upd_reg  <= upd_new;
                a_reg    <= aval[31:0];
            end
            ST_U_BW: begin
                if (div_rsp.done) beta_reg <= div_rsp.quot;
            end
            ST_U_A2: begin
                alpha_reg <= 48'((65'(prod_reg) +
                             (beta_reg[32] ? {1'b0, a_reg, 32'b0} : 65'd0)) >> 16);
                idx_reg   <= (cnt_reg == '0) ? WADDR_W'(FEATURE_COUNT) : '0;
            end
            ST_E_AC1: x_reg <= last_elem ? $signed(ONE_Q) : $signed(frd_reg);
            ST_E_AC2: acc_reg <= prod_reg;
            ST_E_AC3: ac_reg <= ac_new;
            ST_E_D1:  acc_reg <= prod_reg;
            ST_E_D2:  nmean_reg <= mean_new;
            ST_E_X2:  x2_reg <= x2_new;
            ST_E_T1:  acc_reg <= prod_reg;
            ST_E_T2:  d_reg <= d_new;
            ST_E_DW: begin
                if (div_rsp.done && !last_elem) begin
                    if (idx_reg + 1'b1 == cnt_reg) idx_reg <= WADDR_W'(FEATURE_COUNT);
                    else                           idx_reg <= idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign res.margin = m_reg;
    assign res.pred   = (m_reg > 32'sd0);
    assign res.loss   = loss_reg;
    assign res.upd    = upd_reg;

endmodule

/* rtl/arow_online_classifier_core.sv */
// Top level of the AROW online classifier: stream ports, rate register, result register.
// Each feature item is accepted, then the multiplier forms |w|*|x|, x^2 and var*x^2,
// and only then is the next item taken. A last item first reads the bias entry;
// a training update then divides for beta and walks each element and the bias through
// the 33-step divider and the multiplier. The result register lets the next item in while
// a result waits to be taken. After reset the weight memory is cleared with s_tready low.
module arow_online_classifier_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] feature_value, [32] label_positive
    input  logic [0:0]  s_tuser,   // [0] opcode
    input  logic        s_tlast,   // last_feature
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] margin, [32] predicted_positive, [33] loss,
                                   // [34] updated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import arow_pkg::*;

    logic [31:0] rate_reg;
    logic        m_valid_reg;
    res_t        mres_reg;
    res_t        res;
    logic        res_valid;
    logic        out_free;

    // Regularization rate register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn)       rate_reg <= ONE_Q;
        else if (cfg_valid) rate_reg <= cfg_data;
    end

    assign out_free = !m_valid_reg || m_tready;

    arow_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_train  (s_tuser[0]),
        .in_x      ($signed(s_tdata[31:0])),
        .in_pos    (s_tdata[32]),
        .in_last   (s_tlast),
        .rate      (rate_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn)       m_valid_reg <= 1'b0;
        else if (res_valid) m_valid_reg <= 1'b1;
        else if (m_tready)  m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (res_valid) mres_reg <= res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, mres_reg.upd, mres_reg.loss, mres_reg.pred, mres_reg.margin};

`ifndef SYNTH
    // Clearing pass keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input open during weight clear");

    // A new result only lands in a free result register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result register overwritten");

    // A loss always triggers an update
    a_loss_updates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33]) |-> m_tdata[34])
        else $error("loss without update");
`endif

endmodule

/* test/arow_online_classifier_core_tb.sv */
// Self-checking testbench for the AROW online classifier core: predicts every result and checks it.
module arow_online_classifier_core_tb;
    import arow_pkg::*;

    localparam int          NFEAT      = FEATURE_COUNT;
    localparam int          CYCLE_CAP  = 2000000;
    localparam int          SETTLE_CYC = 4000;    // a full update walk of 65 entries, with margin
    localparam logic [63:0] BIG_CAP    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] CONF_CAP   = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] AC_CAP     = 64'h0001_0000_0000_0000;
    localparam logic [63:0] DELTA_CAP  = 64'h0000_0002_0000_0000;
    localparam longint      MSUM_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      MSUM_MIN   = -MSUM_MAX - 1;

    typedef enum logic { OP_PREDICT = 1'b0, OP_TRAIN = 1'b1 } opcode_t;
    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN } rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    arow_online_classifier_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Classifier shadow state
    logic signed [31:0] mean_q [NFEAT+1];
    logic [31:0]        variance_q [NFEAT+1];
    logic signed [31:0] fstore [NFEAT];
    int                 elem_cnt;
    longint             msum;
    longint unsigned    csum;
    logic [31:0]        rate_q;

    res_t   pending_results [$];
    int     fail_cnt    = 0;
    int     item_cnt    = 0;
    int     vector_cnt  = 0;
    int     result_cnt  = 0;
    int     update_cnt  = 0;
    int     cycle_cnt   = 0;
    int     burst_left  = 0;
    bit     sender_gaps = 1'b1;
    int     hold_cycles = 0;
    rx_mode_t rx_mode   = RX_ALWAYS;

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run-time limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned mul_q(longint unsigned a, longint unsigned b,
                                              longint unsigned cap);
        logic [127:0]    full;
        longint unsigned q;
        full = {64'd0, a} * {64'd0, b};
        if (full[127:64] != 0) return cap;
        q = full[63:0] >> 16;
        return (q > cap) ? cap : q;
    endfunction

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] shrink_variance(logic [31:0] v, longint unsigned x2,
                                                    longint unsigned r);
        longint unsigned den, num;
        den = r + mul_q(longint'(v), x2, BIG_CAP);
        num = longint'(v) * r;
        return 32'(num / den);
    endfunction

    function automatic void reset_model();
        for (int i = 0; i <= NFEAT; i++) begin
            mean_q[i]     = '0;
            variance_q[i] = ONE_Q;
        end
        for (int i = 0; i < NFEAT; i++) fstore[i] = '0;
        elem_cnt = 0;
        msum     = 0;
        csum     = 0;
        rate_q   = ONE_Q;
    endfunction

    // AROW step: beta from the confidence, then every stored element and the bias
    function automatic void learn(bit pos, longint ym);
        longint unsigned r, v, beta, alpha, ac, delta, mx;
        bit              up;
        r = (rate_q == 0) ? 64'd1 : longint'(rate_q);
        v = csum + longint'(variance_q[NFEAT]);
        if (v > CONF_CAP) v = CONF_CAP;
        beta  = (64'd1 << 32) / (v + r);
        alpha = mul_q(longint'(65536) - ym, beta, BIG_CAP);
        for (int i = 0; i < elem_cnt && i < NFEAT; i++) begin
            up    = pos != (fstore[i] < 0);
            mx    = mag(fstore[i]);
            ac    = mul_q(alpha, longint'(variance_q[i]), AC_CAP);
            delta = mul_q(ac, mx, DELTA_CAP);
            mean_q[i] = sat32(longint'(mean_q[i]) + (up ? longint'(delta) : -longint'(delta)));
            variance_q[i] = shrink_variance(variance_q[i], (mx * mx) >> 16, r);
        end
        delta = mul_q(alpha, longint'(variance_q[NFEAT]), DELTA_CAP);
        mean_q[NFEAT] = sat32(longint'(mean_q[NFEAT]) +
                              (pos ? longint'(delta) : -longint'(delta)));
        variance_q[NFEAT] = shrink_variance(variance_q[NFEAT], 64'd65536, r);
    endfunction

    // One accepted feature; returns 1 with the expected result on a last feature
    function automatic bit classify_feature(opcode_t op, logic signed [31:0] x, bit pos,
                                            bit last, output res_t res);
        longint unsigned mx, p, c;
        longint          ym;
        logic signed [31:0] w, m;
        res = '0;
        if (elem_cnt < NFEAT) begin
            mx = mag(x);
            w  = mean_q[elem_cnt];
            p  = mul_q(mag(w), mx, BIG_CAP);
            fstore[elem_cnt] = x;
            msum = msum + (((w < 0) != (x < 0)) ? -longint'(p) : longint'(p));
            if (msum > MSUM_MAX) msum = MSUM_MAX;
            if (msum < MSUM_MIN) msum = MSUM_MIN;
            c = mul_q(longint'(variance_q[elem_cnt]), (mx * mx) >> 16, CONF_CAP);
            csum = csum + c;
            if (csum > CONF_CAP) csum = CONF_CAP;
            elem_cnt++;
        end
        if (!last) return 1'b0;
        m = sat32(msum + longint'(mean_q[NFEAT]));
        res.margin = m;
        res.pred   = m > 0;
        if (op == OP_TRAIN) begin
            ym = pos ? longint'(m) : -longint'(m);
            res.loss = ym < 0;
            if (ym < 65536) begin
                learn(pos, ym);
                res.upd = 1'b1;
            end
        end
        elem_cnt = 0;
        msum     = 0;
        csum     = 0;
        return 1'b1;
    endfunction

    // ---------------- receiver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default:   m_tready <= (((cycle_cnt % 11) < 6) || ((cycle_cnt % 7) == 0));
            endcase
        end
    end

    // Result checker
    always @(posedge aclk) begin
        res_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.margin = m_tdata[31:0];
            got.pred   = m_tdata[32];
            got.loss   = m_tdata[33];
            got.upd    = m_tdata[34];
            result_cnt++;
            if (pending_results.size() == 0) begin
                $error("unexpected result item: margin %h", got.margin);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (got.margin !== want.margin) begin
                    $error("margin: expected %h, got %h", want.margin, got.margin);
                    fail_cnt++;
                end
                if (got.pred !== want.pred) begin
                    $error("predicted_positive: expected %b, got %b", want.pred, got.pred);
                    fail_cnt++;
                end
                if (got.loss !== want.loss) begin
                    $error("loss: expected %b, got %b", want.loss, got.loss);
                    fail_cnt++;
                end
                if (got.upd !== want.upd) begin
                    $error("updated: expected %b, got %b", want.upd, got.upd);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------- sender ----------------
    task automatic send_feature(opcode_t op, logic [31:0] x, bit pos, bit last);
        res_t res;
        int   gap;
        if (sender_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pos, x};
        s_tuser  <= op;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        item_cnt++;
        if (classify_feature(op, x, pos, last, res)) begin
            pending_results.push_back(res);
            vector_cnt++;
            if (res.upd) update_cnt++;
        end
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        go_quiet();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Rate write with the block idle, after any update walk has finished
    task automatic write_rate(logic [31:0] r);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_q = r;
    endtask

    function automatic logic [31:0] rand_feature();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return 32'($urandom_range(0, 32'h0004_0000)) * (($urandom_range(0, 1)) ? -1 : 1);
        if (k < 8) return $urandom;
        if (k == 8) return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return 32'd0;
    endfunction

    // Whole vector; the non-last items carry random opcode and label noise
    task automatic send_vector(int len, opcode_t op, bit pos);
        for (int i = 0; i < len - 1; i++)
            send_feature(opcode_t'($urandom_range(0, 1)), rand_feature(),
                         1'($urandom_range(0, 1)), 1'b0);
        send_feature(op, rand_feature(), pos, 1'b1);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_feature(OP_PREDICT, 32'd0, 1'b0, 1'b1);
        send_feature(OP_TRAIN, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_feature(OP_TRAIN, 32'h8000_0000, 1'b1, 1'b1);
        send_feature(OP_TRAIN, 32'h8000_0000, 1'b0, 1'b1);
        send_feature(OP_TRAIN, 32'h7FFF_FFFF, 1'b0, 1'b1);
        // opcode and label of the last feature rule
        send_feature(OP_PREDICT, ONE_Q, 1'b0, 1'b0);
        send_feature(OP_PREDICT, -ONE_Q, 1'b0, 1'b0);
        send_feature(OP_TRAIN, 32'h0002_8000, 1'b1, 1'b1);
        send_feature(OP_TRAIN, ONE_Q, 1'b0, 1'b0);
        send_feature(OP_PREDICT, ONE_Q, 1'b1, 1'b1);
        send_feature(OP_TRAIN, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_feature(OP_TRAIN, 32'h0000_0001, 1'b0, 1'b1);
        send_feature(OP_PREDICT, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_feature(OP_PREDICT, 32'h8000_0000, 1'b0, 1'b1);
    endtask

    // Exactly full and over-long vectors
    task automatic test_vector_lengths();
        send_vector(NFEAT, OP_TRAIN, 1'b1);
        send_vector(NFEAT + 6, OP_TRAIN, 1'b0);
        send_vector(NFEAT + 1, OP_PREDICT, 1'b1);
    endtask

    task automatic test_random(int n_items);
        int stop_at, len, k;
        stop_at = item_cnt + n_items;
        while (item_cnt < stop_at) begin
            k = $urandom_range(0, 19);
            if (k < 14)       len = $urandom_range(1, 8);
            else if (k < 18)  len = $urandom_range(9, NFEAT - 1);
            else if (k == 18) len = NFEAT;
            else              len = $urandom_range(NFEAT + 1, NFEAT + 8);
            send_vector(len, ($urandom_range(0, 3) != 0) ? OP_TRAIN : OP_PREDICT,
                        1'($urandom_range(0, 1)));
        end
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        wait_drained();
        sender_gaps = 1'b0;
        hold_cycles = 3000;
        for (int i = 0; i < 40; i++)
            send_vector($urandom_range(1, 3), opcode_t'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    initial begin
        reset_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rx_mode = RX_ALWAYS;
        test_directed();
        test_vector_lengths();
        rx_mode = RX_RANDOM;
        test_random(270);
        test_backpressure();

        write_rate(32'd1);
        rx_mode = RX_PATTERN;
        test_directed();
        test_random(240);

        write_rate(32'hFFFF_FFFF);
        rx_mode = RX_RANDOM;
        test_directed();
        test_random(240);

        write_rate(32'd0);
        rx_mode = RX_ALWAYS;
        test_random(200);

        write_rate($urandom_range(1, 32'h0010_0000));
        rx_mode = RX_PATTERN;
        test_vector_lengths();
        test_random(240);

        write_rate(ONE_Q);
        rx_mode = RX_RANDOM;
        test_random(190);

        wait_drained();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result items never arrived", pending_results.size());
            fail_cnt++;
        end
        $display("Sent %0d feature items in %0d vectors over six rate settings.",
                 item_cnt, vector_cnt);
        $display("Checked %0d result items, %0d of them with a weight update.",
                 result_cnt, update_cnt);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
